>>> hw/rtl/rotc_pkg.sv
package rotc_pkg;

  // Field and datapath widths
  localparam int CB     = 32;   // vector and axis component width, Q16.16
  localparam int ANG_W  = 32;   // angle width, Q4.27
  localparam int ZT_W   = 16;   // zero threshold register width
  localparam int ROOT_W = 31;   // scaled axis magnitude, norm and quotient width
  localparam int SQ_W   = 62;   // sum of squares width
  localparam int NUM_W  = 61;   // dividend width
  localparam int CS_W   = 34;   // CORDIC x/y, cosine and sine width, Q2.30
  localparam int TH_W   = 64;   // angle accumulator width, Q60
  localparam int PW     = 72;   // product width before rounding

  // Register indexes
  localparam logic [0:0] REG_ZERO_THR = 1'b0;

  // Angle constants
  localparam logic signed [TH_W-1:0] PI_Q60         = 64'sh3243F6A8885A308D;
  localparam logic signed [TH_W-1:0] HALF_PI_Q60    = 64'sh1921FB54442D1846;
  localparam logic signed [TH_W-1:0] QUARTER_PI_Q60 = 64'sh0C90FDAA22168C23;
  localparam logic signed [TH_W-1:0] PI_Q58         = QUARTER_PI_Q60;
  localparam logic signed [TH_W-1:0] TWO_PI_Q58     = HALF_PI_Q60;
  localparam logic signed [CS_W-1:0] GAIN_Q30       = 34'sd652032874;

  // Item context that travels with every stage
  typedef struct packed {
    logic [2:0][CB-1:0]     vec;
    logic [2:0][ROOT_W-1:0] amag;
    logic [2:0]             aneg;
    logic                   null_ax;
    logic                   flip;
    logic [SQ_W-1:0]        sq;
    logic [CS_W-1:0]        cos_v;
    logic [CS_W-1:0]        sin_v;
  } rotc_carry_t;

  // Round a product with a Q2.30 factor, half up
  function automatic logic signed [PW-1:0] rnd30(input logic signed [PW-1:0] p);
    rnd30 = (p + (72'sd1 <<< 29)) >>> 30;
  endfunction

  // Unsigned quotient by shift and subtract; used only while elaborating
  function automatic logic [TH_W-1:0] cdiv(input logic [TH_W-1:0] num,
                                           input logic [TH_W-1:0] den);
    logic [TH_W-1:0] q;
    logic [TH_W:0]   r;
    q = '0;
    r = '0;
    for (int b = TH_W - 1; b >= 0; b--) begin
      r = {r[TH_W-1:0], num[b]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    cdiv = q;
  endfunction

  // atan(2^-i) in Q60: pi/4 at i = 0, else its power series; constant per stage
  function automatic logic signed [TH_W-1:0] atan_q60(input int i);
    logic signed [TH_W-1:0] acc;
    logic signed [TH_W-1:0] term;
    int e;
    acc = '0;
    if (i == 0) begin
      acc = QUARTER_PI_Q60;
    end else begin
      for (int k = 0; k < 31; k++) begin
        e = 60 - i * (2 * k + 1);
        if (e >= 0) begin
          term = $signed(cdiv(64'd1 << e, TH_W'(2 * k + 1)));
          acc = k[0] ? acc - term : acc + term;
        end
      end
    end
    atan_q60 = acc;
  endfunction

endpackage

>>> hw/rtl/rotc_front.sv
module rotc_front
  import rotc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   valid_i,
  input  logic [2:0][CB-1:0]     vec_i,
  input  logic [2:0][CB-1:0]     axis_i,
  input  logic [ANG_W-1:0]       angle_i,
  input  logic [ZT_W-1:0]        thr_i,
  output logic                   valid_o,
  output rotc_carry_t            car_o,
  output logic signed [TH_W-1:0] th_o
);

  localparam logic signed [TH_W-1:0] PI3_Q58 = 3 * PI_Q58;
  localparam logic signed [TH_W-1:0] PI5_Q58 = 5 * PI_Q58;

  // Stage 1: magnitudes, null test, angle reduction
  logic [ZT_W-1:0]        thr;
  logic [2:0][CB-1:0]     mag;
  logic                   null_nxt;
  logic [CB-1:0]          max_nxt;
  logic signed [TH_W-1:0] th_raw;
  logic [1:0]             kpos;
  logic [1:0]             kneg;
  logic signed [TH_W-1:0] off_pos;
  logic signed [TH_W-1:0] off_neg;
  logic signed [TH_W-1:0] thr58_nxt;

  logic                   v1_r;
  logic [2:0][CB-1:0]     vec1_r;
  logic [2:0][CB-1:0]     ax1_r;
  logic                   null1_r;
  logic [CB-1:0]          max1_r;
  logic signed [TH_W-1:0] th1_r;

  always_comb begin
    thr = (thr_i == '0) ? ZT_W'(1) : thr_i;
    null_nxt = 1'b1;
    max_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = axis_i[i][CB-1] ? (~axis_i[i] + CB'(1)) : axis_i[i];
      if (mag[i] >= CB'(thr)) null_nxt = 1'b0;
      if (mag[i] > max_nxt) max_nxt = mag[i];
    end
    th_raw = TH_W'($signed(angle_i)) <<< 31;
    kpos = 2'd0;
    kneg = 2'd0;
    if (th_raw > PI_Q58) kpos = 2'd1;
    if (th_raw > PI3_Q58) kpos = 2'd2;
    if (th_raw > PI5_Q58) kpos = 2'd3;
    if (th_raw < -PI_Q58) kneg = 2'd1;
    if (th_raw < -PI3_Q58) kneg = 2'd2;
    if (th_raw < -PI5_Q58) kneg = 2'd3;
    case (kpos)
      2'd0:    off_pos = '0;
      2'd1:    off_pos = TWO_PI_Q58;
      2'd2:    off_pos = 2 * TWO_PI_Q58;
      default: off_pos = 3 * TWO_PI_Q58;
    endcase
    case (kneg)
      2'd0:    off_neg = '0;
      2'd1:    off_neg = TWO_PI_Q58;
      2'd2:    off_neg = 2 * TWO_PI_Q58;
      default: off_neg = 3 * TWO_PI_Q58;
    endcase
    thr58_nxt = th_raw - off_pos + off_neg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec1_r  <= vec_i;
      ax1_r   <= axis_i;
      null1_r <= null_nxt;
      max1_r  <= max_nxt;
      th1_r   <= thr58_nxt;
    end
  end

  // Stage 2: scale axis so its largest magnitude lands near 2^30, fold angle
  logic [5:0]             len;
  logic signed [CB-1:0]   sa;
  logic signed [CB-1:0]   sc;
  rotc_carry_t            car2_nxt;
  logic signed [TH_W-1:0] th60;
  logic signed [TH_W-1:0] th2_nxt;

  logic                   v2_r;
  rotc_carry_t            car2_r;
  logic signed [TH_W-1:0] th2_r;

  always_comb begin
    len = '0;
    for (int b = 0; b < CB; b++) begin
      if (max1_r[b]) len = 6'(b + 1);
    end
    car2_nxt = '0;
    car2_nxt.vec = vec1_r;
    car2_nxt.null_ax = null1_r;
    sa = '0;
    sc = '0;
    for (int i = 0; i < 3; i++) begin
      sa = $signed(ax1_r[i]);
      if (len > 6'd30) sc = sa >>> (len - 6'd30);
      else sc = sa <<< (6'd30 - len);
      car2_nxt.aneg[i] = sc[CB-1];
      car2_nxt.amag[i] = sc[CB-1] ? ROOT_W'(-sc) : ROOT_W'(sc);
    end
    th60 = th1_r <<< 2;
    th2_nxt = th60;
    if (th60 > HALF_PI_Q60) begin
      th2_nxt = th60 - PI_Q60;
      car2_nxt.flip = 1'b1;
    end else if (th60 < -HALF_PI_Q60) begin
      th2_nxt = th60 + PI_Q60;
      car2_nxt.flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      car2_r <= car2_nxt;
      th2_r  <= th2_nxt;
    end
  end

  // Stage 3: square the scaled magnitudes
  logic                   v3_r;
  rotc_carry_t            car3_r;
  logic signed [TH_W-1:0] th3_r;
  logic [2:0][SQ_W-1:0]   sqr3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      car3_r <= car2_r;
      th3_r  <= th2_r;
      for (int i = 0; i < 3; i++) begin
        sqr3_r[i] <= SQ_W'(car2_r.amag[i]) * SQ_W'(car2_r.amag[i]);
      end
    end
  end

  // Stage 4: sum of squares
  rotc_carry_t car4_nxt;
  logic        v4_r;
  rotc_carry_t car4_r;
  logic signed [TH_W-1:0] th4_r;

  always_comb begin
    car4_nxt = car3_r;
    car4_nxt.sq = sqr3_r[0] + sqr3_r[1] + sqr3_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      car4_r <= car4_nxt;
      th4_r  <= th3_r;
    end
  end

  assign valid_o = v4_r;
  assign car_o   = car4_r;
  assign th_o    = th4_r;

endmodule

>>> hw/rtl/rotc_cordic_cell.sv
module rotc_cordic_cell
  import rotc_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   valid_i,
  input  rotc_carry_t            car_i,
  input  logic signed [CS_W-1:0] x_i,
  input  logic signed [CS_W-1:0] y_i,
  input  logic signed [TH_W-1:0] th_i,
  output logic                   valid_o,
  output rotc_carry_t            car_o,
  output logic signed [CS_W-1:0] x_o,
  output logic signed [CS_W-1:0] y_o,
  output logic signed [TH_W-1:0] th_o
);

  localparam logic signed [TH_W-1:0] ATAN = atan_q60(IDX);

  logic                   valid_r;
  rotc_carry_t            car_r;
  logic signed [CS_W-1:0] x_r;
  logic signed [CS_W-1:0] x_nxt;
  logic signed [CS_W-1:0] y_r;
  logic signed [CS_W-1:0] y_nxt;
  logic signed [TH_W-1:0] th_r;
  logic signed [TH_W-1:0] th_nxt;

  // Rotate toward zero residual angle
  always_comb begin
    if (!th_i[TH_W-1]) begin
      x_nxt  = x_i - (y_i >>> IDX);
      y_nxt  = y_i + (x_i >>> IDX);
      th_nxt = th_i - ATAN;
    end else begin
      x_nxt  = x_i + (y_i >>> IDX);
      y_nxt  = y_i - (x_i >>> IDX);
      th_nxt = th_i + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      car_r <= car_i;
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      th_r  <= th_nxt;
    end
  end

  assign valid_o = valid_r;
  assign car_o   = car_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign th_o    = th_r;

endmodule

>>> hw/rtl/rotc_sqrt_cell.sv
module rotc_sqrt_cell
  import rotc_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_i,
  input  rotc_carry_t       car_i,
  input  logic [ROOT_W-1:0] root_i,
  input  logic [ROOT_W+2:0] rem_i,
  output logic              valid_o,
  output rotc_carry_t       car_o,
  output logic [ROOT_W-1:0] root_o,
  output logic [ROOT_W+2:0] rem_o
);

  localparam int RW = ROOT_W + 3;

  logic [RW-1:0]     rem_sh;
  logic [RW-1:0]     trial;
  logic [RW-1:0]     rem_nxt;
  logic [ROOT_W-1:0] root_nxt;
  logic              valid_r;
  rotc_carry_t       car_r;
  logic [ROOT_W-1:0] root_r;
  logic [RW-1:0]     rem_r;

  // Bring down two radicand bits and try the next root bit
  always_comb begin
    rem_sh = {rem_i[RW-3:0], car_i.sq[SQ_W-1-2*IDX -: 2]};
    trial  = {1'b0, root_i, 2'b01};
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {root_i[ROOT_W-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {root_i[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      car_r  <= car_i;
      root_r <= root_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign valid_o = valid_r;
  assign car_o   = car_r;
  assign root_o  = root_r;
  assign rem_o   = rem_r;

endmodule

>>> hw/rtl/rotc_div_cell.sv
module rotc_div_cell
  import rotc_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   valid_i,
  input  rotc_carry_t            car_i,
  input  logic [ROOT_W-1:0]      n_i,
  input  logic [2:0][NUM_W-1:0]  num_i,
  input  logic [2:0][ROOT_W-1:0] rem_i,
  input  logic [2:0][ROOT_W-1:0] quo_i,
  output logic                   valid_o,
  output rotc_carry_t            car_o,
  output logic [ROOT_W-1:0]      n_o,
  output logic [2:0][NUM_W-1:0]  num_o,
  output logic [2:0][ROOT_W-1:0] rem_o,
  output logic [2:0][ROOT_W-1:0] quo_o
);

  localparam int BIT = ROOT_W - 1 - IDX;

  logic [2:0][ROOT_W:0]   rsh;
  logic [2:0][ROOT_W-1:0] rem_nxt;
  logic [2:0][ROOT_W-1:0] quo_nxt;
  logic                   valid_r;
  rotc_carry_t            car_r;
  logic [ROOT_W-1:0]      n_r;
  logic [2:0][NUM_W-1:0]  num_r;
  logic [2:0][ROOT_W-1:0] rem_r;
  logic [2:0][ROOT_W-1:0] quo_r;

  // One restoring division step in each of the three lanes
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rsh[l] = {rem_i[l], num_i[l][BIT]};
      if (rsh[l] >= {1'b0, n_i}) begin
        rem_nxt[l] = ROOT_W'(rsh[l] - {1'b0, n_i});
        quo_nxt[l] = {quo_i[l][ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[l] = ROOT_W'(rsh[l]);
        quo_nxt[l] = {quo_i[l][ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      car_r <= car_i;
      n_r   <= n_i;
      num_r <= num_i;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign valid_o = valid_r;
  assign car_o   = car_r;
  assign n_o     = n_r;
  assign num_o   = num_r;
  assign rem_o   = rem_r;
  assign quo_o   = quo_r;

endmodule

>>> hw/rtl/rotc_mix.sv
module rotc_mix
  import rotc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   valid_i,
  input  rotc_carry_t            car_i,
  input  logic [2:0][ROOT_W-1:0] quo_i,
  output logic                   valid_o,
  output logic [2:0][CB-1:0]     vec_o,
  output logic                   err_o
);

  localparam logic signed [CB-1:0] SAT_HI = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] SAT_LO = {1'b1, {(CB-1){1'b0}}};

  // Stage 1: unit axis, all vector-axis products and v*c
  logic signed [CB-1:0]   u_nxt [3];
  logic                   m1_v_r;
  logic                   m1_null_r;
  logic signed [CB-1:0]   m1_u_r [3];
  logic signed [32:0]     m1_vu_r [3][3];
  logic signed [34:0]     m1_vc_r [3];
  logic signed [CS_W-1:0] m1_c_r;
  logic signed [CS_W-1:0] m1_s_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_nxt[i] = car_i.aneg[i] ? -$signed({1'b0, quo_i[i]}) : $signed({1'b0, quo_i[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else if (en) begin
      m1_v_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_null_r <= car_i.null_ax;
      m1_c_r    <= $signed(car_i.cos_v);
      m1_s_r    <= $signed(car_i.sin_v);
      for (int i = 0; i < 3; i++) begin
        m1_u_r[i]  <= u_nxt[i];
        m1_vc_r[i] <= 35'(rnd30(PW'($signed(car_i.vec[i])) * PW'($signed(car_i.cos_v))));
        for (int j = 0; j < 3; j++) begin
          m1_vu_r[i][j] <= 33'(rnd30(PW'($signed(car_i.vec[i])) * PW'(u_nxt[j])));
        end
      end
    end
  end

  // Stage 2: dot product, cross product, one minus cosine
  logic                   m2_v_r;
  logic                   m2_null_r;
  logic signed [CB-1:0]   m2_u_r [3];
  logic signed [34:0]     m2_vc_r [3];
  logic signed [34:0]     m2_d_r;
  logic signed [34:0]     m2_omc_r;
  logic signed [33:0]     m2_cr_r [3];
  logic signed [CS_W-1:0] m2_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_v_r <= 1'b0;
    end else if (en) begin
      m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_null_r <= m1_null_r;
      m2_u_r    <= m1_u_r;
      m2_vc_r   <= m1_vc_r;
      m2_s_r    <= m1_s_r;
      m2_d_r    <= 35'(m1_vu_r[0][0]) + 35'(m1_vu_r[1][1]) + 35'(m1_vu_r[2][2]);
      m2_omc_r  <= (35'sd1 <<< 30) - 35'(m1_c_r);
      m2_cr_r[0] <= 34'(m1_vu_r[2][1]) - 34'(m1_vu_r[1][2]);
      m2_cr_r[1] <= 34'(m1_vu_r[0][2]) - 34'(m1_vu_r[2][0]);
      m2_cr_r[2] <= 34'(m1_vu_r[1][0]) - 34'(m1_vu_r[0][1]);
    end
  end

  // Stage 3: k = d*(1-c), cross times sine
  logic                 m3_v_r;
  logic                 m3_null_r;
  logic signed [CB-1:0] m3_u_r [3];
  logic signed [34:0]   m3_vc_r [3];
  logic signed [35:0]   m3_k_r;
  logic signed [35:0]   m3_crs_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_v_r <= 1'b0;
    end else if (en) begin
      m3_v_r <= m2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m3_null_r <= m2_null_r;
      m3_u_r    <= m2_u_r;
      m3_vc_r   <= m2_vc_r;
      m3_k_r    <= 36'(rnd30(PW'(m2_d_r) * PW'(m2_omc_r)));
      for (int i = 0; i < 3; i++) begin
        m3_crs_r[i] <= 36'(rnd30(PW'(m2_cr_r[i]) * PW'(m2_s_r)));
      end
    end
  end

  // Stage 4: k times unit axis
  logic               m4_v_r;
  logic               m4_null_r;
  logic signed [34:0] m4_vc_r [3];
  logic signed [35:0] m4_crs_r [3];
  logic signed [35:0] m4_ku_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m4_v_r <= 1'b0;
    end else if (en) begin
      m4_v_r <= m3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m4_null_r <= m3_null_r;
      m4_vc_r   <= m3_vc_r;
      m4_crs_r  <= m3_crs_r;
      for (int i = 0; i < 3; i++) begin
        m4_ku_r[i] <= 36'(rnd30(PW'(m3_k_r) * PW'(m3_u_r[i])));
      end
    end
  end

  // Stage 5: sum, saturate, blank on null axis; this is the output register
  logic signed [37:0]    sum [3];
  logic [2:0][CB-1:0]    vec_nxt;
  logic                  out_v_r;
  logic [2:0][CB-1:0]    vec_r;
  logic                  err_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = 38'(m4_vc_r[i]) + 38'(m4_ku_r[i]) + 38'(m4_crs_r[i]);
      if (m4_null_r) vec_nxt[i] = '0;
      else if (sum[i] > 38'(SAT_HI)) vec_nxt[i] = SAT_HI;
      else if (sum[i] < 38'(SAT_LO)) vec_nxt[i] = SAT_LO;
      else vec_nxt[i] = CB'(sum[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= m4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
      err_r <= m4_null_r;
    end
  end

  assign valid_o = out_v_r;
  assign vec_o   = vec_r;
  assign err_o   = err_r;

endmodule

>>> hw/rtl/vector_axis_angle_rotation_core.sv
// Rotates a 3D vector about an arbitrary axis by an angle (Rodrigues formula).
// Input stream: in_tvalid/in_tready/in_tdata carry one item per handshake:
//   vector, axis (any length, Q16.16) and angle (radians, Q4.27).
// Output stream: out_tdata carries the rotated vector (Q16.16, saturated),
//   out_tuser flags a null axis, in which case the vector is zero.
// Configuration: APB port, register 0 at address 0 is the zero threshold.
// Throughput: one item per cycle, sustained, while the receiver keeps up.
// Pipeline: 4 front cells, CORDIC_STAGES CORDIC cells, 31 square root cells
//   (one root bit each), 31 divider cells (one quotient bit per lane each) and
//   5 product cells, the last of which is the output register.
// Stall: while a result waits in the output register and out_tready is low,
//   the whole chain holds and in_tready drops; nothing is lost or repeated.
// Reset: rst_n (synchronous, active low) empties the chain and sets the
//   zero threshold to 1.
module vector_axis_angle_rotation_core
  import rotc_pkg::*;
#(
  parameter int CORDIC_STAGES = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [223:0]  in_tdata,   // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, turn_angle
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [95:0]   out_tdata,  // out_x, out_y, out_z
  output logic [0:0]    out_tuser,  // axis_zero_error
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  // Configuration register
  logic [ZT_W-1:0] zt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zt_r <= ZT_W'(1);
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ZERO_THR) begin
      zt_r <= pwdata[ZT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ZERO_THR) ? 32'(zt_r) : '0;

  // Advance the chain whenever the output register is free or being taken
  logic adv;
  logic mix_valid;

  assign adv       = !mix_valid || out_tready;
  assign in_tready = adv;

  // Front cells
  logic [2:0][CB-1:0]     in_vec;
  logic [2:0][CB-1:0]     in_axis;
  logic                   fr_valid;
  rotc_carry_t            fr_car;
  logic signed [TH_W-1:0] fr_th;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_vec[i]  = in_tdata[i*CB +: CB];
      in_axis[i] = in_tdata[(3+i)*CB +: CB];
    end
  end

  rotc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .valid_i (in_tvalid),
    .vec_i   (in_vec),
    .axis_i  (in_axis),
    .angle_i (in_tdata[6*CB +: ANG_W]),
    .thr_i   (zt_r),
    .valid_o (fr_valid),
    .car_o   (fr_car),
    .th_o    (fr_th)
  );

  // CORDIC chain
  logic                   cor_v   [CORDIC_STAGES+1];
  rotc_carry_t            cor_car [CORDIC_STAGES+1];
  logic signed [CS_W-1:0] cor_x   [CORDIC_STAGES+1];
  logic signed [CS_W-1:0] cor_y   [CORDIC_STAGES+1];
  logic signed [TH_W-1:0] cor_th  [CORDIC_STAGES+1];

  assign cor_v[0]   = fr_valid;
  assign cor_car[0] = fr_car;
  assign cor_x[0]   = GAIN_Q30;
  assign cor_y[0]   = '0;
  assign cor_th[0]  = fr_th;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    rotc_cordic_cell #(.IDX(g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .valid_i (cor_v[g]),
      .car_i   (cor_car[g]),
      .x_i     (cor_x[g]),
      .y_i     (cor_y[g]),
      .th_i    (cor_th[g]),
      .valid_o (cor_v[g+1]),
      .car_o   (cor_car[g+1]),
      .x_o     (cor_x[g+1]),
      .y_o     (cor_y[g+1]),
      .th_o    (cor_th[g+1])
    );
  end

  // Square root chain; cosine and sine join the context here
  logic              sq_v    [ROOT_W+1];
  rotc_carry_t       sq_car  [ROOT_W+1];
  logic [ROOT_W-1:0] sq_root [ROOT_W+1];
  logic [ROOT_W+2:0] sq_rem  [ROOT_W+1];

  always_comb begin
    sq_car[0] = cor_car[CORDIC_STAGES];
    sq_car[0].cos_v = cor_car[CORDIC_STAGES].flip ? CS_W'(-cor_x[CORDIC_STAGES])
                                                  : cor_x[CORDIC_STAGES];
    sq_car[0].sin_v = cor_car[CORDIC_STAGES].flip ? CS_W'(-cor_y[CORDIC_STAGES])
                                                  : cor_y[CORDIC_STAGES];
  end

  assign sq_v[0]    = cor_v[CORDIC_STAGES];
  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;

  for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
    rotc_sqrt_cell #(.IDX(g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .valid_i (sq_v[g]),
      .car_i   (sq_car[g]),
      .root_i  (sq_root[g]),
      .rem_i   (sq_rem[g]),
      .valid_o (sq_v[g+1]),
      .car_o   (sq_car[g+1]),
      .root_o  (sq_root[g+1]),
      .rem_o   (sq_rem[g+1])
    );
  end

  // Divider chain: unit component = (|a| * 2^30 + n/2) / n in three lanes
  logic                   dv_v   [ROOT_W+1];
  rotc_carry_t            dv_car [ROOT_W+1];
  logic [ROOT_W-1:0]      dv_n   [ROOT_W+1];
  logic [2:0][NUM_W-1:0]  dv_num [ROOT_W+1];
  logic [2:0][ROOT_W-1:0] dv_rem [ROOT_W+1];
  logic [2:0][ROOT_W-1:0] dv_quo [ROOT_W+1];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      dv_num[0][l] = {sq_car[ROOT_W].amag[l], 30'b0} + NUM_W'(sq_root[ROOT_W] >> 1);
      dv_rem[0][l] = ROOT_W'(dv_num[0][l][NUM_W-1:ROOT_W]);
      dv_quo[0][l] = '0;
    end
  end

  assign dv_v[0]   = sq_v[ROOT_W];
  assign dv_car[0] = sq_car[ROOT_W];
  assign dv_n[0]   = sq_root[ROOT_W];

  for (genvar g = 0; g < ROOT_W; g++) begin : g_div
    rotc_div_cell #(.IDX(g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .valid_i (dv_v[g]),
      .car_i   (dv_car[g]),
      .n_i     (dv_n[g]),
      .num_i   (dv_num[g]),
      .rem_i   (dv_rem[g]),
      .quo_i   (dv_quo[g]),
      .valid_o (dv_v[g+1]),
      .car_o   (dv_car[g+1]),
      .n_o     (dv_n[g+1]),
      .num_o   (dv_num[g+1]),
      .rem_o   (dv_rem[g+1]),
      .quo_o   (dv_quo[g+1])
    );
  end

  // Products, sums and output register
  logic [2:0][CB-1:0] mix_vec;
  logic               mix_err;

  rotc_mix u_mix (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .valid_i (dv_v[ROOT_W]),
    .car_i   (dv_car[ROOT_W]),
    .quo_i   (dv_quo[ROOT_W]),
    .valid_o (mix_valid),
    .vec_o   (mix_vec),
    .err_o   (mix_err)
  );

  assign out_tvalid   = mix_valid;
  assign out_tdata    = {mix_vec[2], mix_vec[1], mix_vec[0]};
  assign out_tuser[0] = mix_err;

  // A null axis always yields a zero vector
  a_null_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("null axis result not zero");

  // A waiting result blocks new items
  a_stall_blocks : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("item accepted while output stalled");

  // Reset empties the chain
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present after reset");

endmodule
